FILE: hdl/bmps_pkg.sv
// Shared types, register indexes, reset values and task constants of the
// battery monitor and power switch core. No dependencies.
`default_nettype none
package bmps_pkg;

   // task codes carried in func
   localparam logic [1:0] FUNC_VOLTAGE = 2'd0;
   localparam logic [1:0] FUNC_PIN     = 2'd1;
   localparam logic [1:0] FUNC_SWITCH  = 2'd2;

   // configuration register indexes
   localparam int unsigned CSR_INDEX_W = 4;
   localparam int unsigned CSR_DATA_W  = 20;
   localparam logic [CSR_INDEX_W-1:0] REG_FAULT_THRESHOLD     = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_LOWER_THRESHOLD     = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_LOWEST_THRESHOLD    = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_HALL_PERIOD_LIMIT   = 4'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_SWITCH_THRESHOLD    = 4'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_AUTO_OFF_LIMIT      = 4'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_DEBOUNCE_COUNT      = 4'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_LOWEST_UPDATE_COUNT = 4'd7;

   // register reset values
   localparam logic [11:0] RST_FAULT_THRESHOLD     = 12'd720;
   localparam logic [11:0] RST_LOWER_THRESHOLD     = 12'd1373;
   localparam logic [11:0] RST_LOWEST_THRESHOLD    = 12'd1360;
   localparam logic [15:0] RST_HALL_PERIOD_LIMIT   = 16'd1350;
   localparam logic [11:0] RST_SWITCH_THRESHOLD    = 12'd1240;
   localparam logic [19:0] RST_AUTO_OFF_LIMIT      = 20'd292968;
   localparam logic [7:0]  RST_DEBOUNCE_COUNT      = 8'd10;
   localparam logic [7:0]  RST_LOWEST_UPDATE_COUNT = 8'd80;

   // task constants
   localparam logic [15:0]        LOWEST_RESET  = 16'hFFFF;
   localparam logic signed [15:0] QUALIFY_LIMIT = 16'sd105;
   localparam logic [9:0]         SINCE_MAX     = 10'd1000;
   localparam logic [9:0]         LONG_PRESS    = 10'd800;
   localparam logic [8:0]         RELEASE_MIN   = 9'd6;
   localparam logic [8:0]         RELEASE_MAX   = 9'd500;

   // configuration bundle
   typedef struct packed {
      logic [11:0] fault_threshold;
      logic [11:0] lower_threshold;
      logic [11:0] lowest_threshold;
      logic [15:0] hall_period_limit;
      logic [11:0] switch_threshold;
      logic [19:0] auto_off_limit;
      logic [7:0]  debounce_count;
      logic [7:0]  lowest_update_count;
   } cfg_type;

   // one registered input transaction
   typedef struct packed {
      logic [1:0]         func;
      logic [11:0]        sample_0;
      logic [11:0]        sample_1;
      logic [11:0]        sample_2;
      logic [11:0]        sample_3;
      logic signed [15:0] current_diff;
      logic [15:0]        hall_period;
      logic               low_pin;
      logic               motor_moving;
      logic               external_fault;
   } item_type;

   // status reported with every result
   typedef struct packed {
      logic [11:0] battery_average;
      logic        battery_fault;
      logic        voltage_lower;
      logic        voltage_lowest;
      logic        low_run_out;
      logic        battery_low;
      logic        powered_on;
      logic        power_off;
      logic [15:0] lowest_voltage;
   } status_type;

endpackage
`default_nettype wire

FILE: hdl/bmps_csr.sv
// Configuration register file of the battery monitor core.
// Depends on bmps_pkg for the register indexes, reset values and cfg_type.
`default_nettype none
module bmps_csr (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  csr_valid,
   output logic                                 csr_ready,
   input  wire  [bmps_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire  [bmps_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output bmps_pkg::cfg_type                    cfg
);
   import bmps_pkg::*;

   cfg_type cfg_ff;
   logic    write;

   // writes are always accepted at once, csr_ready is tied high
   assign csr_ready = 1'b1;
   assign write     = csr_valid & csr_ready;
   assign cfg       = cfg_ff;

   // register writes, unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fault_threshold     <= RST_FAULT_THRESHOLD;
         cfg_ff.lower_threshold     <= RST_LOWER_THRESHOLD;
         cfg_ff.lowest_threshold    <= RST_LOWEST_THRESHOLD;
         cfg_ff.hall_period_limit   <= RST_HALL_PERIOD_LIMIT;
         cfg_ff.switch_threshold    <= RST_SWITCH_THRESHOLD;
         cfg_ff.auto_off_limit      <= RST_AUTO_OFF_LIMIT;
         cfg_ff.debounce_count      <= RST_DEBOUNCE_COUNT;
         cfg_ff.lowest_update_count <= RST_LOWEST_UPDATE_COUNT;
      end else if (write) begin
         unique case (csr_index)
            REG_FAULT_THRESHOLD:     cfg_ff.fault_threshold     <= csr_wdata[11:0];
            REG_LOWER_THRESHOLD:     cfg_ff.lower_threshold     <= csr_wdata[11:0];
            REG_LOWEST_THRESHOLD:    cfg_ff.lowest_threshold    <= csr_wdata[11:0];
            REG_HALL_PERIOD_LIMIT:   cfg_ff.hall_period_limit   <= csr_wdata[15:0];
            REG_SWITCH_THRESHOLD:    cfg_ff.switch_threshold    <= csr_wdata[11:0];
            REG_AUTO_OFF_LIMIT:      cfg_ff.auto_off_limit      <= csr_wdata[19:0];
            REG_DEBOUNCE_COUNT:      cfg_ff.debounce_count      <= csr_wdata[7:0];
            REG_LOWEST_UPDATE_COUNT: cfg_ff.lowest_update_count <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

endmodule
`default_nettype wire

FILE: hdl/bmps_engine.sv
// Supervisor state and the three housekeeping tasks: voltage, pin debounce
// and power switch. Depends on bmps_pkg for item, status and cfg types.
`default_nettype none
module bmps_engine (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    advance,
   input  bmps_pkg::item_type     item,
   input  bmps_pkg::cfg_type      cfg,
   output bmps_pkg::status_type   status
);
   import bmps_pkg::*;

   logic [15:0] lowest_level_ff, lowest_level_in;
   logic [7:0]  drop_counter_ff, drop_counter_in;
   logic        fault_latch_ff, fault_latch_in;
   logic [2:0]  level_flags_ff, level_flags_in;
   logic        low_flag_ff, low_flag_in;
   logic [7:0]  pin_high_counter_ff, pin_high_counter_in;
   logic [7:0]  pin_low_counter_ff, pin_low_counter_in;
   logic        on_flag_ff, on_flag_in;
   logic [9:0]  since_start_counter_ff, since_start_counter_in;
   logic [8:0]  released_counter_ff, released_counter_in;
   logic [19:0] auto_off_counter_ff, auto_off_counter_in;
   logic        off_latch_ff, off_latch_in;

   logic [13:0] sample_sum;
   logic [11:0] average;
   logic        qualify;
   logic        pressed;
   logic [9:0]  since_inc;
   logic [15:0] lowest_tmp;
   logic        lower_bit, lowest_bit, runout_bit;

   // average of the four samples
   assign sample_sum = {2'b00, item.sample_0} + {2'b00, item.sample_1}
                     + {2'b00, item.sample_2} + {2'b00, item.sample_3};
   assign average    = sample_sum[13:2];

   assign qualify   = (item.current_diff > 16'sd0) && (item.current_diff < QUALIFY_LIMIT)
                    && (lowest_level_ff > {4'b0000, average});
   assign pressed   = average <= cfg.switch_threshold;
   assign since_inc = (since_start_counter_ff < SINCE_MAX) ? since_start_counter_ff + 10'd1
                                                            : since_start_counter_ff;

   // lowest level after the slow update and the battery-low override
   always_comb begin
      lowest_tmp      = lowest_level_ff;
      drop_counter_in = drop_counter_ff;
      if (qualify) begin
         if (drop_counter_ff >= cfg.lowest_update_count) begin
            drop_counter_in = 8'd0;
            lowest_tmp      = {4'b0000, average};
         end else begin
            drop_counter_in = drop_counter_ff + 8'd1;
         end
      end
      if (low_flag_ff) begin
         lowest_tmp = {4'b0000, average};
      end
   end

   assign lower_bit  = lowest_tmp < {4'b0000, cfg.lower_threshold};
   assign lowest_bit = lowest_tmp <= {4'b0000, cfg.lowest_threshold};
   assign runout_bit = (item.hall_period < cfg.hall_period_limit) && lowest_bit;

   // next state by task
   always_comb begin
      lowest_level_in        = lowest_level_ff;
      fault_latch_in         = fault_latch_ff;
      level_flags_in         = level_flags_ff;
      low_flag_in            = low_flag_ff;
      pin_high_counter_in    = pin_high_counter_ff;
      pin_low_counter_in     = pin_low_counter_ff;
      on_flag_in             = on_flag_ff;
      since_start_counter_in = since_start_counter_ff;
      released_counter_in    = released_counter_ff;
      auto_off_counter_in    = auto_off_counter_ff;
      off_latch_in           = off_latch_ff;
      unique case (item.func)
         FUNC_VOLTAGE: begin
            if (average <= cfg.fault_threshold) begin
               fault_latch_in = 1'b1;
            end
            lowest_level_in = lowest_tmp;
            level_flags_in  = {runout_bit, lowest_bit, lower_bit};
         end
         FUNC_PIN: begin
            if (item.low_pin) begin
               pin_low_counter_in = 8'd0;
               if (pin_high_counter_ff >= cfg.debounce_count) begin
                  low_flag_in = 1'b0;
               end else begin
                  pin_high_counter_in = pin_high_counter_ff + 8'd1;
               end
            end else begin
               pin_high_counter_in = 8'd0;
               if (pin_low_counter_ff >= cfg.debounce_count) begin
                  low_flag_in = 1'b1;
               end else begin
                  pin_low_counter_in = pin_low_counter_ff + 8'd1;
               end
            end
         end
         FUNC_SWITCH: begin
            since_start_counter_in = since_inc;
            if (!on_flag_ff) begin
               if (pressed) begin
                  on_flag_in = 1'b1;
               end
            end else begin
               // press after a release: powers off once since_start reaches LONG_PRESS, else sets it there
               if (pressed) begin
                  if (released_counter_ff > RELEASE_MIN) begin
                     if (since_inc >= LONG_PRESS) begin
                        off_latch_in = 1'b1;
                     end else begin
                        since_start_counter_in = LONG_PRESS;
                     end
                  end
                  released_counter_in = 9'd0;
               end else if (released_counter_ff < RELEASE_MAX) begin
                  released_counter_in = released_counter_ff + 9'd1;
               end
               // auto-off while moving with a fault present
               if (item.motor_moving && (fault_latch_ff || item.external_fault)) begin
                  if (auto_off_counter_ff >= cfg.auto_off_limit) begin
                     off_latch_in = 1'b1;
                  end else begin
                     auto_off_counter_in = auto_off_counter_ff + 20'd1;
                  end
               end else begin
                  auto_off_counter_in = 20'd0;
               end
            end
         end
         default: ;
      endcase
   end

   // state registers, updated once per transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         lowest_level_ff        <= LOWEST_RESET;
         drop_counter_ff        <= 8'd0;
         fault_latch_ff         <= 1'b0;
         level_flags_ff         <= 3'd0;
         low_flag_ff            <= 1'b0;
         pin_high_counter_ff    <= 8'd0;
         pin_low_counter_ff     <= 8'd0;
         on_flag_ff             <= 1'b0;
         since_start_counter_ff <= 10'd0;
         released_counter_ff    <= 9'd0;
         auto_off_counter_ff    <= 20'd0;
         off_latch_ff           <= 1'b0;
      end else if (advance) begin
         lowest_level_ff        <= lowest_level_in;
         if (item.func == FUNC_VOLTAGE) begin
            drop_counter_ff     <= drop_counter_in;
         end
         fault_latch_ff         <= fault_latch_in;
         level_flags_ff         <= level_flags_in;
         low_flag_ff            <= low_flag_in;
         pin_high_counter_ff    <= pin_high_counter_in;
         pin_low_counter_ff     <= pin_low_counter_in;
         on_flag_ff             <= on_flag_in;
         since_start_counter_ff <= since_start_counter_in;
         released_counter_ff    <= released_counter_in;
         auto_off_counter_ff    <= auto_off_counter_in;
         off_latch_ff           <= off_latch_in;
      end
   end

   // status after this transaction
   assign status.battery_average = average;
   assign status.battery_fault   = fault_latch_in;
   assign status.voltage_lower   = level_flags_in[0];
   assign status.voltage_lowest  = level_flags_in[1];
   assign status.low_run_out     = level_flags_in[2];
   assign status.battery_low     = low_flag_in;
   assign status.powered_on      = on_flag_in;
   assign status.power_off       = off_latch_in;
   assign status.lowest_voltage  = lowest_level_in;

endmodule
`default_nettype wire

FILE: hdl/battery_monitor_power_switch_core.sv
// Battery monitor and power switch core, top level: input register, task
// engine and result register. Depends on bmps_pkg, bmps_csr and bmps_engine.
//
// One transaction is accepted per clock while req_stall is low, and each
// gives one result: the input register feeds the task engine, whose status
// and state update are captured together in the result register.
// While a result is stalled, one more transaction is held in the input
// register before req_stall rises. Configuration writes complete at once
// (csr_ready is always high) and are meant to be made only while idle.
`default_nettype none
module battery_monitor_power_switch_core (
   input  wire                               clock,
   input  wire                               reset,
   // request channel
   input  wire                               req_valid,
   output logic                              req_stall,
   input  wire  [1:0]                        req_func,
   input  wire  [11:0]                       req_sample_0,
   input  wire  [11:0]                       req_sample_1,
   input  wire  [11:0]                       req_sample_2,
   input  wire  [11:0]                       req_sample_3,
   input  wire  signed [15:0]                req_current_diff,
   input  wire  [15:0]                       req_hall_period,
   input  wire                               req_low_pin,
   input  wire                               req_motor_moving,
   input  wire                               req_external_fault,
   // response channel
   output logic                              rsp_valid,
   input  wire                               rsp_stall,
   output logic [11:0]                       rsp_battery_average,
   output logic                              rsp_battery_fault,
   output logic                              rsp_voltage_lower,
   output logic                              rsp_voltage_lowest,
   output logic                              rsp_low_run_out,
   output logic                              rsp_battery_low,
   output logic                              rsp_powered_on,
   output logic                              rsp_power_off,
   output logic [15:0]                       rsp_lowest_voltage,
   // configuration channel
   input  wire                               csr_valid,
   output logic                              csr_ready,
   input  wire  [bmps_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire  [bmps_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import bmps_pkg::*;

   cfg_type    cfg;
   item_type   item_ff;
   logic       item_valid_ff;
   status_type status;
   status_type result_ff;
   logic       result_valid_ff;
   logic       advance;
   logic       accept;

   // handshake: the held item moves on when the result register is free
   assign advance   = item_valid_ff & (~result_valid_ff | ~rsp_stall);
   assign req_stall = item_valid_ff & ~advance;
   assign accept    = req_valid & ~req_stall;

   bmps_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // input register control
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (accept) begin
         item_valid_ff <= 1'b1;
      end else if (advance) begin
         item_valid_ff <= 1'b0;
      end
   end

   // input register payload
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.func           <= req_func;
         item_ff.sample_0       <= req_sample_0;
         item_ff.sample_1       <= req_sample_1;
         item_ff.sample_2       <= req_sample_2;
         item_ff.sample_3       <= req_sample_3;
         item_ff.current_diff   <= req_current_diff;
         item_ff.hall_period    <= req_hall_period;
         item_ff.low_pin        <= req_low_pin;
         item_ff.motor_moving   <= req_motor_moving;
         item_ff.external_fault <= req_external_fault;
      end
   end

   bmps_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item_ff),
      .cfg     (cfg),
      .status  (status)
   );

   // result register control
   always_ff @(posedge clock) begin
      if (reset) begin
         result_valid_ff <= 1'b0;
      end else if (advance) begin
         result_valid_ff <= 1'b1;
      end else if (~rsp_stall) begin
         result_valid_ff <= 1'b0;
      end
   end

   // result register payload
   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= status;
      end
   end

   assign rsp_valid           = result_valid_ff;
   assign rsp_battery_average = result_ff.battery_average;
   assign rsp_battery_fault   = result_ff.battery_fault;
   assign rsp_voltage_lower   = result_ff.voltage_lower;
   assign rsp_voltage_lowest  = result_ff.voltage_lowest;
   assign rsp_low_run_out     = result_ff.low_run_out;
   assign rsp_battery_low     = result_ff.battery_low;
   assign rsp_powered_on      = result_ff.powered_on;
   assign rsp_power_off       = result_ff.power_off;
   assign rsp_lowest_voltage  = result_ff.lowest_voltage;

endmodule
`default_nettype wire

FILE: sim/tb_battery_monitor_power_switch_core.sv
// Self-checking testbench for battery_monitor_power_switch_core: a cycle-free
// predictor of the supervisor tasks checks every status result in order.
// Depends on bmps_pkg and the core; needs no files or arguments.
module tb_battery_monitor_power_switch_core;
   timeunit 1ns;
   timeprecision 1ps;
   import bmps_pkg::*;

   // task code that runs nothing, and the fixed task constants
   localparam logic [1:0] FUNC_UNUSED     = 2'd3;
   localparam int         QUALIFY_BOUND   = 105;
   localparam int         SINCE_CAP       = 1000;
   localparam int         LONG_PRESS_AT   = 800;
   localparam int         RELEASE_MIN_CNT = 6;
   localparam int         RELEASE_CAP     = 500;

   typedef struct {
      logic [15:0] lowest_level;
      logic [7:0]  drop_count;
      logic        fault;
      logic [2:0]  flags;
      logic        low;
      logic [7:0]  pin_high;
      logic [7:0]  pin_low;
      logic        on;
      logic [9:0]  since;
      logic [8:0]  released;
      logic [19:0] auto_off;
      logic        off;
   } supervisor_state_type;

   typedef struct {
      logic [CSR_INDEX_W-1:0] reg_idx;
      logic [CSR_DATA_W-1:0]  reg_val;
   } reg_write_type;

   logic clock;
   logic reset = 1'b1;

   logic     req_valid = 1'b0;
   logic     req_stall;
   item_type req_item = '0;

   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [11:0] rsp_battery_average;
   logic        rsp_battery_fault;
   logic        rsp_voltage_lower;
   logic        rsp_voltage_lowest;
   logic        rsp_low_run_out;
   logic        rsp_battery_low;
   logic        rsp_powered_on;
   logic        rsp_power_off;
   logic [15:0] rsp_lowest_voltage;

   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // predictor copy of the state and the registers
   supervisor_state_type sup;
   cfg_type              reg_copy;

   item_type      pending_tasks[$];
   status_type    status_due[$];
   reg_write_type reg_plan[$];
   status_type    due;

   int errors = 0;
   int sender_idle_pct = 0;
   int rsp_hold_pct = 0;
   bit pin_level = 1'b1;
   bit press_held = 1'b0;
   bit press_first;

   battery_monitor_power_switch_core dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_func           (req_item.func),
      .req_sample_0       (req_item.sample_0),
      .req_sample_1       (req_item.sample_1),
      .req_sample_2       (req_item.sample_2),
      .req_sample_3       (req_item.sample_3),
      .req_current_diff   (req_item.current_diff),
      .req_hall_period    (req_item.hall_period),
      .req_low_pin        (req_item.low_pin),
      .req_motor_moving   (req_item.motor_moving),
      .req_external_fault (req_item.external_fault),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_battery_average(rsp_battery_average),
      .rsp_battery_fault  (rsp_battery_fault),
      .rsp_voltage_lower  (rsp_voltage_lower),
      .rsp_voltage_lowest (rsp_voltage_lowest),
      .rsp_low_run_out    (rsp_low_run_out),
      .rsp_battery_low    (rsp_battery_low),
      .rsp_powered_on     (rsp_powered_on),
      .rsp_power_off      (rsp_power_off),
      .rsp_lowest_voltage (rsp_lowest_voltage),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // predictor: runs one task on the model state and returns the status
   function automatic status_type supervisor_step(input item_type it);
      logic [13:0] sum;
      logic [11:0] avg;
      logic        lower_f;
      logic        lowest_f;
      logic        runout_f;
      status_type  st;
      sum = 14'(it.sample_0) + 14'(it.sample_1) + 14'(it.sample_2) + 14'(it.sample_3);
      avg = sum[13:2];
      case (it.func)
         FUNC_VOLTAGE: begin
            if (avg <= reg_copy.fault_threshold)
               sup.fault = 1'b1;
            if (it.current_diff > 0 && it.current_diff < QUALIFY_BOUND &&
                sup.lowest_level > {4'b0, avg}) begin
               if (sup.drop_count >= reg_copy.lowest_update_count) begin
                  sup.drop_count   = '0;
                  sup.lowest_level = {4'b0, avg};
               end else begin
                  sup.drop_count = sup.drop_count + 8'd1;
               end
            end
            // battery low forces the tracked level to follow the average
            if (sup.low)
               sup.lowest_level = {4'b0, avg};
            lower_f  = sup.lowest_level < {4'b0, reg_copy.lower_threshold};
            lowest_f = sup.lowest_level <= {4'b0, reg_copy.lowest_threshold};
            runout_f = (it.hall_period < reg_copy.hall_period_limit) && lowest_f;
            sup.flags = {runout_f, lowest_f, lower_f};
         end
         FUNC_PIN: begin
            if (it.low_pin) begin
               sup.pin_low = '0;
               if (sup.pin_high >= reg_copy.debounce_count)
                  sup.low = 1'b0;
               else
                  sup.pin_high = sup.pin_high + 8'd1;
            end else begin
               sup.pin_high = '0;
               if (sup.pin_low >= reg_copy.debounce_count)
                  sup.low = 1'b1;
               else
                  sup.pin_low = sup.pin_low + 8'd1;
            end
         end
         FUNC_SWITCH: begin
            if (sup.since < SINCE_CAP)
               sup.since = sup.since + 10'd1;
            if (!sup.on) begin
               if (avg <= reg_copy.switch_threshold)
                  sup.on = 1'b1;
            end else begin
               // press after a release: powers off once since reaches LONG_PRESS_AT, else sets it there
               if (avg <= reg_copy.switch_threshold) begin
                  if (sup.released > RELEASE_MIN_CNT) begin
                     if (sup.since >= LONG_PRESS_AT)
                        sup.off = 1'b1;
                     else
                        sup.since = 10'(LONG_PRESS_AT);
                  end
                  sup.released = '0;
               end else if (sup.released < RELEASE_CAP) begin
                  sup.released = sup.released + 9'd1;
               end
               // auto power-off while moving with a fault present
               if (it.motor_moving && (sup.fault || it.external_fault)) begin
                  if (sup.auto_off >= reg_copy.auto_off_limit)
                     sup.off = 1'b1;
                  else
                     sup.auto_off = sup.auto_off + 20'd1;
               end else begin
                  sup.auto_off = '0;
               end
            end
         end
         default: ;
      endcase
      st.battery_average = avg;
      st.battery_fault   = sup.fault;
      st.voltage_lower   = sup.flags[0];
      st.voltage_lowest  = sup.flags[1];
      st.low_run_out     = sup.flags[2];
      st.battery_low     = sup.low;
      st.powered_on      = sup.on;
      st.power_off       = sup.off;
      st.lowest_voltage  = sup.lowest_level;
      return st;
   endfunction

   function automatic logic [11:0] clip12(input int v);
      if (v < 0)
         return 12'd0;
      if (v > 4095)
         return 12'd4095;
      return v[11:0];
   endfunction

   // four samples spread around a target average
   function automatic item_type with_samples(input item_type it, input int target,
                                             input int j);
      item_type r;
      r = it;
      r.sample_0 = clip12(target + int'($urandom_range(0, 2 * j)) - j);
      r.sample_1 = clip12(target + int'($urandom_range(0, 2 * j)) - j);
      r.sample_2 = clip12(target + int'($urandom_range(0, 2 * j)) - j);
      r.sample_3 = clip12(target + int'($urandom_range(0, 2 * j)) - j);
      return r;
   endfunction

   function automatic item_type mk(input logic [1:0] f, input int s0, input int s1,
                                   input int s2, input int s3, input int cd,
                                   input int hall, input bit pin, input bit mov,
                                   input bit ext);
      item_type it;
      it.func           = f;
      it.sample_0       = s0[11:0];
      it.sample_1       = s1[11:0];
      it.sample_2       = s2[11:0];
      it.sample_3       = s3[11:0];
      it.current_diff   = cd[15:0];
      it.hall_period    = hall[15:0];
      it.low_pin        = pin;
      it.motor_moving   = mov;
      it.external_fault = ext;
      return it;
   endfunction

   // random task transaction; mostly well-formed task sequences, some noise
   function automatic item_type random_item(input bit fault_ok, input bit press_ok);
      logic [95:0] raw;
      item_type    it;
      int          sel;
      int          target;
      int          hall;
      int          sw;
      raw = {$urandom, $urandom, $urandom};
      it  = raw[$bits(item_type)-1:0];
      sel = $urandom_range(99);
      sw  = reg_copy.switch_threshold;
      if (sel < 12) begin
         if (!press_ok && it.func == FUNC_SWITCH)
            it.func = FUNC_PIN;
      end else if (sel < 48) begin
         it.func = FUNC_VOLTAGE;
         case ($urandom_range(3))
            0: target = reg_copy.lower_threshold;
            1: target = reg_copy.lowest_threshold;
            2: target = fault_ok ? int'(reg_copy.fault_threshold) : int'($urandom_range(4095));
            default: target = $urandom_range(4095);
         endcase
         target = target + int'($urandom_range(0, 40)) - 20;
         if (!fault_ok && target <= int'(reg_copy.fault_threshold) + 4)
            target = int'(reg_copy.fault_threshold) + 4 + int'($urandom_range(200));
         it = with_samples(it, target, 3);
         if ($urandom_range(99) < 70) begin
            it.current_diff = 16'($urandom_range(1, QUALIFY_BOUND - 1));
         end else begin
            case ($urandom_range(5))
               0: it.current_diff = 16'sd0;
               1: it.current_diff = 16'(QUALIFY_BOUND);
               2: it.current_diff = -16'sd1;
               3: it.current_diff = 16'h8000;
               4: it.current_diff = 16'h7FFF;
               default: ;
            endcase
         end
         if ($urandom_range(1)) begin
            hall = int'(reg_copy.hall_period_limit) + int'($urandom_range(0, 6)) - 3;
            if (hall < 0)
               hall = 0;
            if (hall > 65535)
               hall = 65535;
            it.hall_period = hall[15:0];
         end
      end else if (sel < 74) begin
         it.func = FUNC_PIN;
         if ($urandom_range(99) < 15)
            pin_level = !pin_level;
         it.low_pin = pin_level;
      end else begin
         it.func = FUNC_SWITCH;
         if (press_ok && $urandom_range(99) < 15)
            press_held = !press_held;
         if (press_ok && press_held)
            target = (sw >= 8) ? int'($urandom_range(0, sw - 8)) : 0;
         else
            target = (sw <= 4087) ? int'($urandom_range(sw + 8, 4095)) : 4095;
         it = with_samples(it, target, 3);
         it.motor_moving   = ($urandom_range(99) < 85);
         it.external_fault = ($urandom_range(99) < 60);
      end
      return it;
   endfunction

   task automatic plan(input logic [CSR_INDEX_W-1:0] idx, input int unsigned val);
      reg_write_type w;
      w.reg_idx = idx;
      w.reg_val = val[CSR_DATA_W-1:0];
      reg_plan.push_back(w);
   endtask

   // register writes back to back; valid drops once after the last one
   task automatic flush_regs();
      reg_write_type w;
      while (reg_plan.size() != 0) begin
         w = reg_plan.pop_front();
         csr_index <= w.reg_idx;
         csr_wdata <= w.reg_val;
         csr_valid <= 1'b1;
         do @(posedge clock); while (!csr_ready);
         case (w.reg_idx)
            REG_FAULT_THRESHOLD:     reg_copy.fault_threshold     = w.reg_val[11:0];
            REG_LOWER_THRESHOLD:     reg_copy.lower_threshold     = w.reg_val[11:0];
            REG_LOWEST_THRESHOLD:    reg_copy.lowest_threshold    = w.reg_val[11:0];
            REG_HALL_PERIOD_LIMIT:   reg_copy.hall_period_limit   = w.reg_val[15:0];
            REG_SWITCH_THRESHOLD:    reg_copy.switch_threshold    = w.reg_val[11:0];
            REG_AUTO_OFF_LIMIT:      reg_copy.auto_off_limit      = w.reg_val[19:0];
            REG_DEBOUNCE_COUNT:      reg_copy.debounce_count      = w.reg_val[7:0];
            REG_LOWEST_UPDATE_COUNT: reg_copy.lowest_update_count = w.reg_val[7:0];
            default: ;
         endcase
      end
      csr_valid <= 1'b0;
   endtask

   // wait until every transaction has been answered, then a short pause;
   // checked between edges so the driver's updates have all landed
   task automatic settle();
      do @(negedge clock);
      while (pending_tasks.size() != 0 || req_valid || status_due.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic run_phase(input int n, input int idle_pct, input int hold_pct,
                            input bit fault_ok, input bit press_ok);
      flush_regs();
      sender_idle_pct = idle_pct;
      rsp_hold_pct    = hold_pct;
      repeat (n) pending_tasks.push_back(random_item(fault_ok, press_ok));
      settle();
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         errors++;
      end
   endtask

   // driver: predicts each accepted transaction, then offers the next one
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            status_due.push_back(supervisor_step(req_item));
         if (!req_valid || !req_stall) begin
            if (pending_tasks.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               req_item  <= pending_tasks.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result side back-pressure
   always @(posedge clock) begin
      if (reset)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= ($urandom_range(99) < rsp_hold_pct);
   end

   // monitor: each accepted result against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (status_due.size() == 0) begin
            $error("result transaction with no request outstanding");
            errors++;
         end else begin
            due = status_due.pop_front();
            check_field("battery_average", due.battery_average, rsp_battery_average);
            check_field("battery_fault", due.battery_fault, rsp_battery_fault);
            check_field("voltage_lower", due.voltage_lower, rsp_voltage_lower);
            check_field("voltage_lowest", due.voltage_lowest, rsp_voltage_lowest);
            check_field("low_run_out", due.low_run_out, rsp_low_run_out);
            check_field("battery_low", due.battery_low, rsp_battery_low);
            check_field("powered_on", due.powered_on, rsp_powered_on);
            check_field("power_off", due.power_off, rsp_power_off);
            check_field("lowest_voltage", due.lowest_voltage, rsp_lowest_voltage);
         end
      end
   end

   initial begin
      sup = '{lowest_level: LOWEST_RESET, default: '0};
      reg_copy.fault_threshold     = RST_FAULT_THRESHOLD;
      reg_copy.lower_threshold     = RST_LOWER_THRESHOLD;
      reg_copy.lowest_threshold    = RST_LOWEST_THRESHOLD;
      reg_copy.hall_period_limit   = RST_HALL_PERIOD_LIMIT;
      reg_copy.switch_threshold    = RST_SWITCH_THRESHOLD;
      reg_copy.auto_off_limit      = RST_AUTO_OFF_LIMIT;
      reg_copy.debounce_count      = RST_DEBOUNCE_COUNT;
      reg_copy.lowest_update_count = RST_LOWEST_UPDATE_COUNT;
      // power-off can latch once only: pick which path is seen first
      press_first = $urandom_range(1);
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: unused task, field extremes, voltage before power-on,
      // debounce, power-on at the threshold and a short release
      pending_tasks.push_back(mk(FUNC_UNUSED, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      pending_tasks.push_back(mk(FUNC_UNUSED, 4095, 4095, 4095, 4095, -1, 65535, 1, 1, 1));
      pending_tasks.push_back(mk(FUNC_VOLTAGE, 4095, 4095, 4095, 4095, 1, 0, 0, 0, 0));
      pending_tasks.push_back(mk(FUNC_VOLTAGE, 4095, 4095, 4095, 4092, 104, 65535, 1, 0, 1));
      pending_tasks.push_back(mk(FUNC_VOLTAGE, 3000, 3001, 3002, 3003, 105, 1349, 0, 1, 0));
      pending_tasks.push_back(mk(FUNC_VOLTAGE, 2000, 2000, 2000, 2000, 0, 1350, 1, 1, 1));
      pending_tasks.push_back(mk(FUNC_VOLTAGE, 1500, 1500, 1501, 1502, -32768, 1351, 0, 0, 1));
      pending_tasks.push_back(mk(FUNC_VOLTAGE, 1400, 1400, 1400, 1400, 32767, 0, 1, 0, 0));
      pending_tasks.push_back(mk(FUNC_VOLTAGE, 721, 721, 721, 722, 50, 100, 0, 0, 0));
      pending_tasks.push_back(mk(FUNC_PIN, 0, 1, 2, 3, 0, 0, 0, 0, 0));
      pending_tasks.push_back(mk(FUNC_PIN, 4095, 0, 4095, 0, 7, 9, 0, 1, 1));
      pending_tasks.push_back(mk(FUNC_PIN, 100, 200, 300, 400, 0, 0, 0, 0, 0));
      pending_tasks.push_back(mk(FUNC_PIN, 10, 20, 30, 40, 0, 0, 1, 0, 0));
      pending_tasks.push_back(mk(FUNC_PIN, 1, 1, 1, 1, 0, 0, 1, 1, 0));
      pending_tasks.push_back(mk(FUNC_SWITCH, 4095, 4095, 4095, 4095, 0, 0, 0, 1, 1));
      pending_tasks.push_back(mk(FUNC_SWITCH, 1240, 1240, 1240, 1240, 0, 0, 0, 0, 0));
      pending_tasks.push_back(mk(FUNC_SWITCH, 1241, 1241, 1241, 1241, 0, 0, 1, 1, 1));
      pending_tasks.push_back(mk(FUNC_SWITCH, 4095, 4095, 4095, 4095, 0, 0, 0, 1, 0));
      pending_tasks.push_back(mk(FUNC_SWITCH, 0, 0, 0, 0, 0, 0, 0, 0, 1));
      pending_tasks.push_back(mk(FUNC_SWITCH, 1241, 1240, 1241, 1241, 0, 0, 1, 1, 1));
      pending_tasks.push_back(mk(FUNC_UNUSED, 1, 2, 3, 4, 12345, 54321, 1, 0, 1));
      settle();

      // phase 1: threshold extremes, fastest counters, no idling
      plan(REG_FAULT_THRESHOLD, 0);
      plan(REG_LOWER_THRESHOLD, 4095);
      plan(REG_LOWEST_THRESHOLD, 0);
      plan(REG_HALL_PERIOD_LIMIT, 65535);
      plan(REG_DEBOUNCE_COUNT, 0);
      plan(REG_LOWEST_UPDATE_COUNT, 0);
      plan(REG_AUTO_OFF_LIMIT, press_first ? 1048575 : 2);
      run_phase(150, 0, 0, 1'b0, press_first);

      // phase 2: nominal thresholds, short counters, sender idling
      plan(REG_LOWER_THRESHOLD, 1373);
      plan(REG_LOWEST_THRESHOLD, 1360);
      plan(REG_HALL_PERIOD_LIMIT, 1350);
      plan(REG_DEBOUNCE_COUNT, 3);
      plan(REG_LOWEST_UPDATE_COUNT, 2);
      plan(REG_AUTO_OFF_LIMIT, 0);
      plan(REG_SWITCH_THRESHOLD, 2000);
      run_phase(150, 45, 0, 1'b0, 1'b1);

      // phase 3: counter maxima, switch always pressed, receiver stalling;
      // a write to an unmapped index must be ignored
      plan(REG_FAULT_THRESHOLD, 720);
      plan(REG_DEBOUNCE_COUNT, 255);
      plan(REG_LOWEST_UPDATE_COUNT, 255);
      plan(REG_AUTO_OFF_LIMIT, 1048575);
      plan(REG_SWITCH_THRESHOLD, 4095);
      plan(REG_HALL_PERIOD_LIMIT, 0);
      plan(CSR_INDEX_W'(REG_LOWEST_UPDATE_COUNT + 1 + $urandom_range(0, 7)), $urandom);
      run_phase(150, 0, 45, 1'b1, 1'b1);

      // phase 4: opposite threshold extremes, light idling on both sides
      plan(REG_FAULT_THRESHOLD, 4095);
      plan(REG_LOWER_THRESHOLD, 0);
      plan(REG_LOWEST_THRESHOLD, 4095);
      plan(REG_SWITCH_THRESHOLD, 0);
      plan(REG_DEBOUNCE_COUNT, 1);
      plan(REG_LOWEST_UPDATE_COUNT, 80);
      plan(REG_HALL_PERIOD_LIMIT, 30000);
      plan(REG_AUTO_OFF_LIMIT, 5);
      run_phase(150, 6, 6, 1'b1, 1'b1);

      // phase 5: random settings, no idling
      plan(REG_FAULT_THRESHOLD, $urandom_range(4095));
      plan(REG_LOWER_THRESHOLD, $urandom_range(4095));
      plan(REG_LOWEST_THRESHOLD, $urandom_range(4095));
      plan(REG_HALL_PERIOD_LIMIT, $urandom_range(65535));
      plan(REG_SWITCH_THRESHOLD, $urandom_range(4095));
      plan(REG_AUTO_OFF_LIMIT, $urandom_range(8));
      plan(REG_DEBOUNCE_COUNT, $urandom_range(6));
      plan(REG_LOWEST_UPDATE_COUNT, $urandom_range(6));
      plan(CSR_INDEX_W'(REG_LOWEST_UPDATE_COUNT + 1 + $urandom_range(0, 7)), $urandom);
      run_phase(150, 0, 0, 1'b1, 1'b1);

      repeat (8) @(posedge clock);
      if (errors == 0 && status_due.size() == 0) begin
         $display("tb_battery_monitor_power_switch_core passed");
      end else begin
         $display("tb_battery_monitor_power_switch_core failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2000000;
      $display("tb_battery_monitor_power_switch_core failed");
      $finish;
   end

endmodule
